@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers shared by the frame receiver front and queue
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ hdl/lpfr_pkg.sv @@
// ----------------------------------------------------------------------------
// lpfr_pkg
// types and constants of the length-prefixed frame receiver
// ----------------------------------------------------------------------------
`default_nettype none

package lpfr_pkg;

    localparam int unsigned HL_W  = 5;
    localparam int unsigned OFF_W = 4;
    localparam int unsigned LEN_W = 16;
    localparam int unsigned CFG_W = 16;
    localparam int unsigned IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_HEADER_LENGTH = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LENGTH_OFFSET = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_LENGTH    = 2'd2;

    localparam logic [HL_W-1:0]  RST_HEADER_LENGTH = 5'd8;
    localparam logic [OFF_W-1:0] RST_LENGTH_OFFSET = 4'd0;
    localparam logic [LEN_W-1:0] RST_MAX_LENGTH    = 16'd29000;

    // queue between front and back
    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_AW    = 2;

    typedef struct packed {
        logic [HL_W-1:0]  header_length;
        logic [OFF_W-1:0] length_offset;
        logic [LEN_W-1:0] max_packet_length;
    } cfg_t;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             first_of_packet;
        logic             last_of_packet;
        logic             header_rejected;
        logic [LEN_W-1:0] packet_length;
    } entry_t;

endpackage

`default_nettype wire

@@ hdl/lpfr_front.sv @@
// ----------------------------------------------------------------------------
// lpfr_front
// collects the header, checks the length field and queues packet bytes
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lpfr_front #(
    parameter int unsigned HEADER_MAX = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire lpfr_pkg::cfg_t  cfg,
    input  wire logic            push,
    output logic                 full,
    input  wire logic [7:0]      data_byte,
    output logic                 q_push,
    output lpfr_pkg::entry_t     q_entry,
    input  wire logic            q_full
);

    import lpfr_pkg::*;

    localparam int unsigned AW = (HEADER_MAX > 1) ? $clog2(HEADER_MAX) : 1;
    localparam int unsigned CW = $clog2(HEADER_MAX + 1);

    localparam logic [2:0] S_HDR   = 3'd0;
    localparam logic [2:0] S_P_HI  = 3'd1;
    localparam logic [2:0] S_P_LO  = 3'd2;
    localparam logic [2:0] S_P_CHK = 3'd3;
    localparam logic [2:0] S_H_RD  = 3'd4;
    localparam logic [2:0] S_H_WR  = 3'd5;
    localparam logic [2:0] S_BODY  = 3'd6;

    logic [2:0]       state_reg,   state_next;
    logic [CW-1:0]    count_reg,   count_next;
    logic [CW-1:0]    hl_reg,      hl_next;
    logic [AW-1:0]    off_reg,     off_next;
    logic [AW-1:0]    idx_reg,     idx_next;
    logic [7:0]       hi_reg,      hi_next;
    logic [LEN_W-1:0] len_reg,     len_next;
    logic [LEN_W-1:0] rem_reg,     rem_next;
    logic [7:0]       rd_data_reg;

    logic [7:0]       mem [HEADER_MAX];

    logic [CW-1:0]    hl_eff;
    logic [CW-1:0]    hl_m2;
    logic [AW-1:0]    off_eff;
    logic [CW-1:0]    count_inc;
    logic             accept;
    logic             wr_en;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [LEN_W-1:0] len_w;
    logic [LEN_W-1:0] hl_len;
    logic             hl_is_last;
    logic             emit_st;
    logic             idx_over;

    // header length clamped to the store, offset kept inside the header
    always_comb
    begin
        if (32'(cfg.header_length) < 32'd2)
        begin
            hl_eff = CW'(2);
        end
        else if (32'(cfg.header_length) > 32'(HEADER_MAX))
        begin
            hl_eff = CW'(HEADER_MAX);
        end
        else
        begin
            hl_eff = CW'(cfg.header_length);
        end
        hl_m2 = hl_eff - CW'(2);
        if (32'(cfg.length_offset) > 32'(hl_m2))
        begin
            off_eff = AW'(hl_m2);
        end
        else
        begin
            off_eff = AW'(cfg.length_offset);
        end
    end

    assign full      = (state_reg == S_BODY) ? q_full : (state_reg != S_HDR);
    assign accept    = push && !full;
    assign count_inc = count_reg + CW'(1);
    assign wr_en     = accept && (state_reg == S_HDR);
    assign len_w     = {hi_reg, rd_data_reg};
    assign hl_len    = LEN_W'(hl_reg);
    assign hl_is_last = (CW'(idx_reg) == (hl_reg - CW'(1)));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        hl_next    = hl_reg;
        off_next   = off_reg;
        idx_next   = idx_reg;
        hi_next    = hi_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        rd_en      = 1'b0;
        rd_addr    = off_reg;
        q_push     = 1'b0;
        q_entry    = '0;

        case (state_reg)
            S_HDR:
            begin
                if (accept)
                begin
                    if (count_inc >= hl_eff)
                    begin
                        count_next = '0;
                        hl_next    = hl_eff;
                        off_next   = off_eff;
                        state_next = S_P_HI;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
            end
            S_P_HI:
            begin
                rd_en      = 1'b1;
                rd_addr    = off_reg;
                state_next = S_P_LO;
            end
            S_P_LO:
            begin
                hi_next    = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = off_reg + AW'(1);
                state_next = S_P_CHK;
            end
            S_P_CHK:
            begin
                if ((len_w < hl_len) || (len_w > cfg.max_packet_length))
                begin
                    q_entry.header_rejected = 1'b1;
                    q_entry.packet_length   = len_w;
                    if (!q_full)
                    begin
                        q_push     = 1'b1;
                        state_next = S_HDR;
                    end
                end
                else
                begin
                    len_next   = len_w;
                    idx_next   = '0;
                    state_next = S_H_RD;
                end
            end
            S_H_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = idx_reg;
                state_next = S_H_WR;
            end
            S_H_WR:
            begin
                q_entry.out_byte        = rd_data_reg;
                q_entry.first_of_packet = (idx_reg == '0);
                q_entry.last_of_packet  = (len_reg == hl_len) && hl_is_last;
                q_entry.packet_length   = len_reg;
                if (!q_full)
                begin
                    q_push = 1'b1;
                    if (hl_is_last)
                    begin
                        if (len_reg > hl_len)
                        begin
                            rem_next   = len_reg - hl_len;
                            state_next = S_BODY;
                        end
                        else
                        begin
                            state_next = S_HDR;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_H_RD;
                    end
                end
            end
            S_BODY:
            begin
                q_entry.out_byte       = data_byte;
                q_entry.last_of_packet = (rem_reg <= LEN_W'(1));
                q_entry.packet_length  = len_reg;
                if (accept)
                begin
                    q_push = 1'b1;
                    if (rem_reg <= LEN_W'(1))
                    begin
                        rem_next   = '0;
                        count_next = '0;
                        state_next = S_HDR;
                    end
                    else
                    begin
                        rem_next = rem_reg - LEN_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_HDR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_HDR;
            count_reg <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hl_reg  <= hl_next;
        off_reg <= off_next;
        idx_reg <= idx_next;
        hi_reg  <= hi_next;
        len_reg <= len_next;
    end

    // header store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= data_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign emit_st  = (state_reg == S_P_CHK) || (state_reg == S_H_WR) || (state_reg == S_BODY);
    assign idx_over = (CW'(idx_reg) >= hl_reg);

    `ASSERT_CLK(a_push_state, clk, rst_n, q_push |-> emit_st, "push outside emitting state")
    `ASSERT_CLK(a_body_rem, clk, rst_n, state_reg == S_BODY |-> rem_reg != '0, "body count zero")
    `ASSERT_NEVER(a_hdr_idx, clk, rst_n, state_reg == S_H_WR && idx_over, "index past header")

endmodule

`default_nettype wire

@@ hdl/lpfr_fifo.sv @@
// ----------------------------------------------------------------------------
// lpfr_fifo
// short queue of result entries between front and back
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module lpfr_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire lpfr_pkg::entry_t  wr_entry,
    output logic                   full,
    input  wire logic              pop,
    output lpfr_pkg::entry_t       head,
    output logic                   empty
);

    import lpfr_pkg::*;

    entry_t          slots [Q_DEPTH];
    logic [Q_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_AW:0]   count_reg,  count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == (Q_AW+1)'(Q_DEPTH));
    assign empty   = (count_reg == '0);
    assign head    = slots[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + Q_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + Q_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (Q_AW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (Q_AW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= wr_entry;
        end
    end

    `ASSERT_NEVER(a_overflow, clk, rst_n, push && full, "push into a full queue")
    `ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > (Q_AW+1)'(Q_DEPTH), "count above depth")

endmodule

`default_nettype wire

@@ hdl/lpfr_back.sv @@
// ----------------------------------------------------------------------------
// lpfr_back
// output register stage that drains the queue toward the consumer
// ----------------------------------------------------------------------------
`default_nettype none

module lpfr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_empty,
    input  wire lpfr_pkg::entry_t  q_head,
    output logic                   q_pop,
    output logic                   empty,
    input  wire logic              pop,
    output lpfr_pkg::entry_t       out_entry
);

    import lpfr_pkg::*;

    logic   valid_reg, valid_next;
    entry_t entry_reg;
    logic   taken;

    assign taken = pop && valid_reg;
    // refill when the stage is free or being drained this cycle
    assign q_pop = !q_empty && (!valid_reg || taken);

    always_comb
    begin
        valid_next = valid_reg;
        if (q_pop)
        begin
            valid_next = 1'b1;
        end
        else if (taken)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            entry_reg <= q_head;
        end
    end

    assign empty     = !valid_reg;
    assign out_entry = entry_reg;

endmodule

`default_nettype wire

@@ hdl/length_prefixed_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_frame_receiver
// deframes a byte stream into length-prefixed packets
// ----------------------------------------------------------------------------
// input side is a queue write port: a byte transfers when push is high and
// full is low. result side is a queue read port: the oldest result sits on
// the result ports while empty is low and transfers when pop is high.
// header bytes are taken one per cycle. after the last header byte full
// stays high while the length field is read back from the header store
// and checked and, for an accepted header, while the header is replayed
// byte by byte through the single store read port. body bytes then
// transfer one per cycle while the queue is not full.
// a result passes through a queue slot and then the output register before
// it reaches the ports, and so does a body byte once it transfers in.
// if the receiver stalls, the 4-entry queue and the output register fill
// and full rises once a header is collected; nothing is dropped.
// reset returns to header collection and loads the register defaults
// (header length 8, offset 0, limit 29000). the header store needs no
// clearing: only bytes of the current header are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_frame_receiver #(
    parameter int unsigned HEADER_MAX = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [lpfr_pkg::IDX_W-1:0] cfg_addr,
    input  wire logic [lpfr_pkg::CFG_W-1:0] cfg_data,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [7:0]                 data_byte,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [7:0]                      out_byte,
    output logic                            first_of_packet,
    output logic                            last_of_packet,
    output logic                            header_rejected,
    output logic [lpfr_pkg::LEN_W-1:0]      packet_length
);

    import lpfr_pkg::*;

    cfg_t   cfg_reg, cfg_next;
    entry_t q_wr_entry;
    entry_t q_head;
    entry_t out_entry;
    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   q_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_addr)
                CFG_HEADER_LENGTH: cfg_next.header_length     = cfg_data[HL_W-1:0];
                CFG_LENGTH_OFFSET: cfg_next.length_offset     = cfg_data[OFF_W-1:0];
                CFG_MAX_LENGTH:    cfg_next.max_packet_length = cfg_data[LEN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_length     <= RST_HEADER_LENGTH;
            cfg_reg.length_offset     <= RST_LENGTH_OFFSET;
            cfg_reg.max_packet_length <= RST_MAX_LENGTH;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lpfr_front #(
        .HEADER_MAX (HEADER_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .data_byte (data_byte),
        .q_push    (q_push),
        .q_entry   (q_wr_entry),
        .q_full    (q_full)
    );

    lpfr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    lpfr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .out_entry (out_entry)
    );

    assign out_byte        = out_entry.out_byte;
    assign first_of_packet = out_entry.first_of_packet;
    assign last_of_packet  = out_entry.last_of_packet;
    assign header_rejected = out_entry.header_rejected;
    assign packet_length   = out_entry.packet_length;

endmodule

`default_nettype wire
